@@ rtl/tsmi_pkg.sv @@
// Shared types and constants for the two-axis stepper move interpolator.
package tsmi_pkg;

  typedef enum logic {
    ACTION_LOAD = 1'b0,
    ACTION_TICK = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ALT_RANGE = 2'd1,
    STATUS_AZ_RANGE  = 2'd2
  } status_e;

  localparam int ANGLE_W = 18;
  localparam int POS_W   = 13;
  localparam int ERR_W   = 15;
  localparam int ALT_W   = 15;   // valid altitude angle width
  localparam int AZ_W    = 17;   // valid azimuth angle width
  localparam int Q_W     = 14;   // quotient width inside the goal math

  localparam logic signed [ANGLE_W-1:0] ALT_VALID_MAX = 18'sd23040;
  localparam logic signed [ANGLE_W-1:0] AZ_VALID_MAX  = 18'sd92160;
  localparam logic [POS_W-1:0] POS_MAX = 13'd8191;

  // full turn is 92160 = 2^11 * 45
  localparam int FULL_SHIFT = 11;
  localparam int H_W        = 19;
  localparam logic [H_W-1:0] DIV45 = 19'd45;
  localparam int RECIP45_SHIFT = 24;
  localparam logic [H_W-1:0] RECIP45 = 19'd372827;   // floor(2^24 / 45)

  localparam int PM_W      = 27;  // az goal times microsteps
  localparam int INV_SHIFT = 27;

  localparam logic signed [ERR_W-1:0] ERR_MIN = -15'sd16384;
  localparam logic signed [ERR_W-1:0] ERR_MAX = 15'sd16383;

  typedef struct packed {
    action_e          action;
    status_e          status;
  } meta_t;

  typedef struct packed {
    action_e          action;
    status_e          status;
    logic [POS_W-1:0] alt_goal;
    logic [POS_W-1:0] az_goal;
  } goal_word_t;

endpackage

@@ rtl/tsmi_if.sv @@
// Valid/ready channels for input words and result words.
interface tsmi_in_if;
  logic                                  valid;
  logic                                  ready;
  tsmi_pkg::action_e                     action;
  logic signed [tsmi_pkg::ANGLE_W-1:0]   alt_angle;
  logic signed [tsmi_pkg::ANGLE_W-1:0]   az_angle;

  modport source (output valid, action, alt_angle, az_angle, input ready);
  modport sink   (input valid, action, alt_angle, az_angle, output ready);
endinterface

interface tsmi_out_if;
  logic                          valid;
  logic                          ready;
  tsmi_pkg::status_e             status;
  logic                          alt_pulse;
  logic                          alt_reverse;
  logic                          az_pulse;
  logic                          az_reverse;
  logic                          in_motion;
  logic [tsmi_pkg::POS_W-1:0]    alt_now;
  logic [tsmi_pkg::POS_W-1:0]    az_now;

  modport source (output valid, status, alt_pulse, alt_reverse, az_pulse, az_reverse,
                  in_motion, alt_now, az_now, input ready);
  modport sink   (input valid, status, alt_pulse, alt_reverse, az_pulse, az_reverse,
                  in_motion, alt_now, az_now, output ready);
endinterface

@@ rtl/tsmi_goal_pipe.sv @@
// Pipelined range check and angle to microstep goal conversion.
module tsmi_goal_pipe #(
  parameter int unsigned AZ_REV_STEPS     = 6400,
  parameter int unsigned ALT_REV_STEPS    = 3733,
  parameter int unsigned MOTOR_MICROSTEPS = 1600
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  tsmi_pkg::action_e                   action_i,
  input  logic signed [tsmi_pkg::ANGLE_W-1:0] alt_angle_i,
  input  logic signed [tsmi_pkg::ANGLE_W-1:0] az_angle_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output tsmi_pkg::goal_word_t                out_word_o
);
  import tsmi_pkg::*;

  localparam int NStages = 7;
  localparam int unsigned InvMulInt = (2 ** INV_SHIFT) / AZ_REV_STEPS;
  localparam int InvW = $clog2(InvMulInt + 1);
  localparam logic [InvW-1:0] InvMul = InvW'(InvMulInt);
  localparam int PinvW = PM_W + InvW;

  logic [NStages-1:0] v_q;
  logic [NStages-1:0] en;
  meta_t              meta_q [NStages];

  // stage payloads
  logic [ALT_W-1:0]   s1_alt_q;
  logic [AZ_W-1:0]    s1_az_q;
  logic [H_W-1:0]     s2_ah_q, s2_zh_q;
  logic [H_W-1:0]     s3_ah_q, s3_zh_q;
  logic [2*H_W-1:0]   s3_ap_q, s3_zp_q;
  logic [Q_W-1:0]     s4_abase_q, s4_zg_q;
  logic [PM_W-1:0]    s5_pm_q;
  logic [Q_W-1:0]     s5_abase_q, s5_zg_q;
  logic [PinvW-1:0]   s6_pinv_q;
  logic [PM_W-1:0]    s6_pm_q;
  logic [Q_W-1:0]     s6_abase_q, s6_zg_q;
  logic [POS_W-1:0]   s7_alt_goal_q, s7_az_goal_q;

  status_e            in_status;
  logic [29:0]        az_prod, alt_prod;
  logic [Q_W-1:0]     aq_est, zq_est, abase_d, zg_d;
  logic [H_W:0]       ar, zr;
  logic [Q_W-1:0]     xq_est, extra;
  logic [PM_W:0]      xr;
  logic [Q_W:0]       alt_sum;
  logic [POS_W-1:0]   alt_goal_d, az_goal_d;

  always_comb begin
    en[NStages-1] = !v_q[NStages-1] || out_ready_i;
    for (int i = NStages - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign in_ready_o = en[0];

  always_comb begin
    if (alt_angle_i < 0 || alt_angle_i > ALT_VALID_MAX) begin
      in_status = STATUS_ALT_RANGE;
    end else if (az_angle_i < 0 || az_angle_i > AZ_VALID_MAX) begin
      in_status = STATUS_AZ_RANGE;
    end else begin
      in_status = STATUS_OK;
    end
  end

  assign alt_prod = 30'(s1_alt_q) * 30'(ALT_REV_STEPS);
  assign az_prod  = 30'(s1_az_q) * 30'(AZ_REV_STEPS);

  // divide by 45: reciprocal estimate is low by at most one
  assign aq_est  = s3_ap_q[RECIP45_SHIFT +: Q_W];
  assign zq_est  = s3_zp_q[RECIP45_SHIFT +: Q_W];
  assign ar      = {1'b0, s3_ah_q} - (H_W+1)'(aq_est) * (H_W+1)'(DIV45);
  assign zr      = {1'b0, s3_zh_q} - (H_W+1)'(zq_est) * (H_W+1)'(DIV45);
  assign abase_d = aq_est + Q_W'(ar >= (H_W+1)'(DIV45));
  assign zg_d    = zq_est + Q_W'(zr >= (H_W+1)'(DIV45));

  // divide by the azimuth steps per turn, same correction scheme
  assign xq_est  = s6_pinv_q[INV_SHIFT +: Q_W];
  assign xr      = {1'b0, s6_pm_q} - (PM_W+1)'(xq_est) * (PM_W+1)'(AZ_REV_STEPS);
  assign extra   = xq_est + Q_W'(xr >= (PM_W+1)'(AZ_REV_STEPS));
  assign alt_sum = (Q_W+1)'(extra) + (Q_W+1)'(s6_abase_q);

  assign alt_goal_d = (alt_sum > (Q_W+1)'(POS_MAX)) ? POS_MAX : alt_sum[POS_W-1:0];
  assign az_goal_d  = (s6_zg_q > Q_W'(POS_MAX)) ? POS_MAX : s6_zg_q[POS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NStages; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      meta_q[0] <= '{action: action_i, status: in_status};
      s1_alt_q  <= alt_angle_i[ALT_W-1:0];
      s1_az_q   <= az_angle_i[AZ_W-1:0];
    end
    for (int i = 1; i < NStages; i++) begin
      if (en[i]) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
    if (en[1]) begin
      s2_ah_q <= H_W'(alt_prod >> FULL_SHIFT);
      s2_zh_q <= H_W'(az_prod >> FULL_SHIFT);
    end
    if (en[2]) begin
      s3_ap_q <= (2*H_W)'(s2_ah_q) * (2*H_W)'(RECIP45);
      s3_zp_q <= (2*H_W)'(s2_zh_q) * (2*H_W)'(RECIP45);
      s3_ah_q <= s2_ah_q;
      s3_zh_q <= s2_zh_q;
    end
    if (en[3]) begin
      s4_abase_q <= abase_d;
      s4_zg_q    <= zg_d;
    end
    if (en[4]) begin
      s5_pm_q    <= PM_W'(s4_zg_q) * PM_W'(MOTOR_MICROSTEPS);
      s5_abase_q <= s4_abase_q;
      s5_zg_q    <= s4_zg_q;
    end
    if (en[5]) begin
      s6_pinv_q  <= PinvW'(s5_pm_q) * PinvW'(InvMul);
      s6_pm_q    <= s5_pm_q;
      s6_abase_q <= s5_abase_q;
      s6_zg_q    <= s5_zg_q;
    end
    if (en[6]) begin
      s7_alt_goal_q <= alt_goal_d;
      s7_az_goal_q  <= az_goal_d;
    end
  end

  assign out_valid_o         = v_q[NStages-1];
  assign out_word_o.action   = meta_q[NStages-1].action;
  assign out_word_o.status   = meta_q[NStages-1].status;
  assign out_word_o.alt_goal = s7_alt_goal_q;
  assign out_word_o.az_goal  = s7_az_goal_q;

endmodule

@@ rtl/two_axis_stepper_move_interpolator_unit.sv @@
// Top level of the two-axis stepper move interpolator.
// Takes load words (altitude and azimuth target in 1/256 degree) and tick words,
// and returns one result word for each: status, step pulses and directions for
// both axes, the moving flag and both positions. Load words are range checked
// and turned into microstep goals in a seven-stage conversion pipeline; the
// axis positions, goals and Bresenham error live in the stage after the pipeline,
// which also holds the result register. A word passes the conversion stages and then
// the result register, and one word is taken every cycle; throughput drops only while the
// result side holds ready low and the pipeline has no empty stage left.
module two_axis_stepper_move_interpolator_unit #(
  parameter int unsigned AZ_REV_STEPS     = 6400,
  parameter int unsigned ALT_REV_STEPS    = 3733,
  parameter int unsigned MOTOR_MICROSTEPS = 1600
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsmi_in_if.sink    in_i,
  tsmi_out_if.source out_o
);
  import tsmi_pkg::*;

  logic             pipe_valid, pipe_ready;
  goal_word_t       pipe_word;

  logic [POS_W-1:0] alt_pos_q, az_pos_q, alt_goal_q, az_goal_q;
  logic [POS_W-1:0] line_major_q, line_minor_q;
  logic signed [ERR_W-1:0] line_err_q;
  logic             alt_major_q;

  logic             out_valid_q;
  status_e          status_q;
  logic             alt_pulse_q, alt_rev_q, az_pulse_q, az_rev_q, moving_q;

  logic             take, load_ok, is_tick;
  logic [POS_W-1:0] alt_goal_d, az_goal_d, alt_pos_d, az_pos_d;
  logic [POS_W-1:0] da, dz, maj_d, min_d;
  logic             alt_major_d;
  logic signed [ERR_W-1:0] err_d;
  logic [POS_W-1:0] mj_pos, mn_pos, mj_goal, mn_goal, mj_next, mn_next;
  logic             mj_step, mn_step;
  logic signed [ERR_W+1:0] e_ext, e1, e2;
  logic             alt_pulse_d, az_pulse_d;

  function automatic logic [POS_W-1:0] toward(logic [POS_W-1:0] pos, logic [POS_W-1:0] goal);
    logic [POS_W-1:0] res;
    res = pos;
    if (pos < goal) begin
      res = pos + 1'b1;
    end else if (pos > goal) begin
      res = pos - 1'b1;
    end
    return res;
  endfunction

  tsmi_goal_pipe #(
    .AZ_REV_STEPS    (AZ_REV_STEPS),
    .ALT_REV_STEPS   (ALT_REV_STEPS),
    .MOTOR_MICROSTEPS(MOTOR_MICROSTEPS)
  ) u_goal_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .action_i   (in_i.action),
    .alt_angle_i(in_i.alt_angle),
    .az_angle_i (in_i.az_angle),
    .out_valid_o(pipe_valid),
    .out_ready_i(pipe_ready),
    .out_word_o (pipe_word)
  );

  assign pipe_ready = !out_valid_q || out_o.ready;
  assign take       = pipe_valid && pipe_ready;
  assign is_tick    = (pipe_word.action == ACTION_TICK);
  assign load_ok    = !is_tick && (pipe_word.status == STATUS_OK);

  assign alt_goal_d = load_ok ? pipe_word.alt_goal : alt_goal_q;
  assign az_goal_d  = load_ok ? pipe_word.az_goal : az_goal_q;

  // line setup from the present positions
  assign da          = (alt_pos_q > alt_goal_d) ? alt_pos_q - alt_goal_d : alt_goal_d - alt_pos_q;
  assign dz          = (az_pos_q > az_goal_d) ? az_pos_q - az_goal_d : az_goal_d - az_pos_q;
  assign alt_major_d = (da >= dz);
  assign maj_d       = alt_major_d ? da : dz;
  assign min_d       = alt_major_d ? dz : da;
  assign err_d       = $signed({1'b0, min_d, 1'b0}) - $signed({2'b00, maj_d});

  // one tick along the line
  assign mj_pos  = alt_major_q ? alt_pos_q : az_pos_q;
  assign mn_pos  = alt_major_q ? az_pos_q : alt_pos_q;
  assign mj_goal = alt_major_q ? alt_goal_q : az_goal_q;
  assign mn_goal = alt_major_q ? az_goal_q : alt_goal_q;
  assign mj_step = (mj_pos != mj_goal);
  assign mn_step = (mn_pos != mn_goal) && (!mj_step || line_err_q > 0);
  assign mj_next = mj_step ? toward(mj_pos, mj_goal) : mj_pos;
  assign mn_next = mn_step ? toward(mn_pos, mn_goal) : mn_pos;

  assign e_ext = {{2{line_err_q[ERR_W-1]}}, line_err_q};
  assign e1    = (line_err_q > 0) ? e_ext - $signed({3'b000, line_major_q, 1'b0}) : e_ext;
  assign e2    = e1 + $signed({3'b000, line_minor_q, 1'b0});

  assign alt_pulse_d = is_tick && (alt_major_q ? mj_step : mn_step);
  assign az_pulse_d  = is_tick && (alt_major_q ? mn_step : mj_step);
  assign alt_pos_d   = !is_tick ? alt_pos_q : (alt_major_q ? mj_next : mn_next);
  assign az_pos_d    = !is_tick ? az_pos_q : (alt_major_q ? mn_next : mj_next);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_pos_q    <= '0;
      az_pos_q     <= '0;
      alt_goal_q   <= '0;
      az_goal_q    <= '0;
      line_major_q <= '0;
      line_minor_q <= '0;
      line_err_q   <= '0;
      alt_major_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      moving_q     <= 1'b0;
    end else begin
      if (take) begin
        out_valid_q <= 1'b1;
        moving_q    <= (alt_pos_d != alt_goal_d) || (az_pos_d != az_goal_d);
        alt_pos_q   <= alt_pos_d;
        az_pos_q    <= az_pos_d;
        if (load_ok) begin
          alt_goal_q   <= alt_goal_d;
          az_goal_q    <= az_goal_d;
          alt_major_q  <= alt_major_d;
          line_major_q <= maj_d;
          line_minor_q <= min_d;
          line_err_q   <= err_d;
        end else if (is_tick && mj_step) begin
          if (e2 < $signed({{2{ERR_MIN[ERR_W-1]}}, ERR_MIN})) begin
            line_err_q <= ERR_MIN;
          end else if (e2 > $signed({2'b00, ERR_MAX})) begin
            line_err_q <= ERR_MAX;
          end else begin
            line_err_q <= e2[ERR_W-1:0];
          end
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q    <= is_tick ? STATUS_OK : pipe_word.status;
      alt_pulse_q <= alt_pulse_d;
      az_pulse_q  <= az_pulse_d;
      alt_rev_q   <= (alt_goal_d < alt_pos_q);
      az_rev_q    <= (az_goal_d < az_pos_q);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.alt_pulse   = alt_pulse_q;
  assign out_o.alt_reverse = alt_rev_q;
  assign out_o.az_pulse    = az_pulse_q;
  assign out_o.az_reverse  = az_rev_q;
  assign out_o.in_motion   = moving_q;
  assign out_o.alt_now     = alt_pos_q;
  assign out_o.az_now      = az_pos_q;

endmodule
